### rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the text whitespace stripper.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int CNT_W = 6;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] HASH_BYTE    = 8'h23;

    typedef struct packed {
        logic [7:0]       ch;
        logic [CNT_W-1:0] cnt;
        logic             nl_pre;
        logic             has_char;
        logic             nl_post;
        logic             done;
        logic             ovf;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       done;
        logic       ovf;
    } res_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

endpackage

### rtl/tws_ram.sv
// ----------------------------------------------------------------------------
// tws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/tws_front.sv
// ----------------------------------------------------------------------------
// tws_front
// Accepts text bytes, tracks line state, stores pending whitespace and
// issues one command per byte that produces output.
// ----------------------------------------------------------------------------
module tws_front #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    input  logic                           store_free,
    output logic                           push,
    output tws_pkg::cmd_t                  cmd,
    output logic                           wr_en,
    output logic [$clog2(SPACE_DEPTH)-1:0] wr_addr,
    output logic [7:0]                     wr_data
);

    localparam int AW = $clog2(SPACE_DEPTH);

    logic                      skip_reg;
    logic                      at_ls_reg, at_ls_next;
    logic                      in_cmt_reg, in_cmt_next;
    logic                      lht_reg, lht_next;
    logic                      bp_reg, bp_next;
    logic                      ae_reg, ae_next;
    logic [tws_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      busy_reg;
    logic                      acc;
    logic                      ws_write;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg && !q_full;
    assign acc       = s_tvalid && s_tready;

    always_comb begin
        at_ls_next  = at_ls_reg;
        in_cmt_next = in_cmt_reg;
        lht_next    = lht_reg;
        bp_next     = bp_reg;
        ae_next     = ae_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        ws_write    = 1'b0;
        cmd         = '0;
        cmd.ch      = s_tdata;

        if (in_cmt_reg) begin
            if (s_tdata == tws_pkg::NEWLINE_BYTE) begin
                in_cmt_next = 1'b0;
                at_ls_next  = 1'b1;
            end
        end else if (at_ls_reg && skip_reg && s_tdata == tws_pkg::HASH_BYTE) begin
            in_cmt_next = 1'b1;
            at_ls_next  = 1'b0;
        end else if (s_tdata == tws_pkg::NEWLINE_BYTE) begin
            if (lht_reg) begin
                cmd.has_char = 1'b1;
            end else begin
                bp_next = 1'b1;
            end
            at_ls_next = 1'b1;
            lht_next   = 1'b0;
            cnt_next   = '0;
        end else if (tws_pkg::is_blank(s_tdata)) begin
            if (cnt_reg < tws_pkg::CNT_W'(SPACE_DEPTH)) begin
                ws_write = 1'b1;
                cnt_next = cnt_reg + tws_pkg::CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
            at_ls_next = 1'b0;
        end else begin
            if (!lht_reg) begin
                cmd.nl_pre = bp_reg && ae_reg;
                bp_next    = 1'b0;
            end
            cmd.cnt      = cnt_reg;
            cmd.has_char = 1'b1;
            cnt_next     = '0;
            lht_next     = 1'b1;
            ae_next      = 1'b1;
            at_ls_next   = 1'b0;
        end

        cmd.nl_post = s_tlast && !in_cmt_next && lht_next;
        cmd.done    = s_tlast;
        cmd.ovf     = ovf_next;
    end

    assign push    = acc && (cmd.has_char || cmd.nl_post || s_tlast);
    assign wr_en   = acc && ws_write;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg   <= 1'b0;
            at_ls_reg  <= 1'b1;
            in_cmt_reg <= 1'b0;
            lht_reg    <= 1'b0;
            bp_reg     <= 1'b0;
            ae_reg     <= 1'b0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                skip_reg <= cfg_data;
            end
            if (push && cmd.cnt != '0) begin
                busy_reg <= 1'b1;
            end else if (store_free) begin
                busy_reg <= 1'b0;
            end
            if (acc) begin
                if (s_tlast) begin
                    at_ls_reg  <= 1'b1;
                    in_cmt_reg <= 1'b0;
                    lht_reg    <= 1'b0;
                    bp_reg     <= 1'b0;
                    ae_reg     <= 1'b0;
                    cnt_reg    <= '0;
                    ovf_reg    <= 1'b0;
                end else begin
                    at_ls_reg  <= at_ls_next;
                    in_cmt_reg <= in_cmt_next;
                    lht_reg    <= lht_next;
                    bp_reg     <= bp_next;
                    ae_reg     <= ae_next;
                    cnt_reg    <= cnt_next;
                    ovf_reg    <= ovf_next;
                end
            end
        end
    end

endmodule

### rtl/tws_queue.sv
// ----------------------------------------------------------------------------
// tws_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module tws_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tws_pkg::cmd_t push_cmd,
    input  logic          pop,
    output tws_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    tws_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/tws_back.sv
// ----------------------------------------------------------------------------
// tws_back
// Executes commands: emits the optional leading newline, held whitespace,
// byte and closing newline, or a bare done marker, into the output register.
// ----------------------------------------------------------------------------
module tws_back #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tws_pkg::cmd_t                  head,
    input  logic                           q_empty,
    output logic                           pop,
    output logic                           store_free,
    output logic                           rd_en,
    output logic [$clog2(SPACE_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                     rd_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tws_pkg::res_t                  m_res
);

    localparam int AW = $clog2(SPACE_DEPTH);

    typedef enum logic [2:0] {
        B_IDLE,
        B_PRE,
        B_RD,
        B_SP,
        B_CHAR,
        B_POST,
        B_BARE
    } state_t;

    state_t                    state_reg;
    tws_pkg::cmd_t             cmd_reg;
    logic [tws_pkg::CNT_W-1:0] idx_reg;
    logic                      m_valid_reg;
    tws_pkg::res_t             m_res_reg;
    logic                      out_free;
    logic                      load;
    logic                      sp_last;
    tws_pkg::res_t             res_next;
    state_t                    first_state;

    assign out_free   = !m_valid_reg || m_ready;
    assign pop        = state_reg == B_IDLE && !q_empty;
    assign rd_en      = state_reg == B_RD;
    assign rd_addr    = idx_reg[AW-1:0];
    assign sp_last    = (idx_reg + tws_pkg::CNT_W'(1)) == cmd_reg.cnt;
    assign store_free = state_reg == B_SP && out_free && sp_last;

    always_comb begin
        if (head.nl_pre) begin
            first_state = B_PRE;
        end else if (head.cnt != '0) begin
            first_state = B_RD;
        end else if (head.has_char) begin
            first_state = B_CHAR;
        end else if (head.nl_post) begin
            first_state = B_POST;
        end else begin
            first_state = B_BARE;
        end
    end

    always_comb begin
        res_next     = '0;
        res_next.ovf = cmd_reg.ovf;
        load         = 1'b0;
        case (state_reg)
            B_PRE: begin
                load           = out_free;
                res_next.data  = tws_pkg::NEWLINE_BYTE;
                res_next.valid = 1'b1;
            end
            B_SP: begin
                load           = out_free;
                res_next.data  = rd_data;
                res_next.valid = 1'b1;
            end
            B_CHAR: begin
                load           = out_free;
                res_next.data  = cmd_reg.ch;
                res_next.valid = 1'b1;
                res_next.last  = !cmd_reg.nl_post;
                res_next.done  = cmd_reg.done && !cmd_reg.nl_post;
            end
            B_POST: begin
                load           = out_free;
                res_next.data  = tws_pkg::NEWLINE_BYTE;
                res_next.valid = 1'b1;
                res_next.last  = 1'b1;
                res_next.done  = cmd_reg.done;
            end
            B_BARE: begin
                load          = out_free;
                res_next.last = 1'b1;
                res_next.done = 1'b1;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                m_res_reg   <= res_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (pop) begin
                        cmd_reg   <= head;
                        idx_reg   <= '0;
                        state_reg <= first_state;
                    end
                end
                B_PRE: begin
                    if (load) begin
                        state_reg <= (cmd_reg.cnt != '0) ? B_RD : B_CHAR;
                    end
                end
                B_RD: begin
                    state_reg <= B_SP;
                end
                B_SP: begin
                    if (load) begin
                        idx_reg   <= idx_reg + tws_pkg::CNT_W'(1);
                        state_reg <= sp_last ? B_CHAR : B_RD;
                    end
                end
                B_CHAR: begin
                    if (load) begin
                        state_reg <= cmd_reg.nl_post ? B_POST : B_IDLE;
                    end
                end
                B_POST, B_BARE: begin
                    if (load) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

### rtl/text_whitespace_stripper.sv
// ----------------------------------------------------------------------------
// text_whitespace_stripper
// Streaming text cleaner: strips trailing whitespace, collapses blank lines,
// optionally drops comment lines and terminates the text with a newline.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the two-entry command queue has room and
// no held whitespace is being released. Bytes that cause no result issue no
// command. The back end takes a command while idle, then emits each plain
// result directly and each held whitespace byte through the store's
// registered read port, a read state followed by an output state. From the
// cycle after the transfer of a byte that releases held whitespace until its
// last held byte reaches the output register no new byte is taken. The output
// register stalls the back end while m_tready is low. Whitespace beyond
// SPACE_DEPTH bytes in one run is dropped and flagged.
// ----------------------------------------------------------------------------
module text_whitespace_stripper #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,      // skip_comment_lines
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // text_byte
    input  logic       s_tlast,       // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_byte
    output logic       m_tlast,       // last_of_run
    output logic [2:0] m_tuser        // byte_valid, text_done, space_overflow
);

    localparam int AW = $clog2(SPACE_DEPTH);

    tws_pkg::cmd_t push_cmd;
    tws_pkg::cmd_t head;
    tws_pkg::res_t m_res;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          store_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    tws_front #(.SPACE_DEPTH(SPACE_DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .store_free (store_free),
        .push       (push),
        .cmd        (push_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    tws_ram #(.WIDTH(8), .DEPTH(SPACE_DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tws_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tws_back #(.SPACE_DEPTH(SPACE_DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .store_free (store_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = m_res.data;
    assign m_tlast = m_res.last;
    assign m_tuser = {m_res.ovf, m_res.done, m_res.valid};

endmodule

### rtl/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_port_checks
// Port-level checks on the stripper's result stream.
// ----------------------------------------------------------------------------
module tws_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("text_done without last_of_run");

    a_bare_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && m_tlast && m_tdata == 8'h00)
        else $error("bare result that is not a done marker");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind text_whitespace_stripper tws_port_checks u_tws_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### dv/tws_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tws_tb_pkg
// Byte codes shared by the whitespace stripper checker and its stimulus.
// ----------------------------------------------------------------------------
package tws_tb_pkg;

    localparam logic [7:0] SPACE_BYTE    = 8'h20;
    localparam logic [7:0] TAB_BYTE      = 8'h09;
    localparam logic [7:0] VTAB_BYTE     = 8'h0B;
    localparam logic [7:0] FORMFEED_BYTE = 8'h0C;
    localparam logic [7:0] CR_BYTE       = 8'h0D;

endpackage

### dv/tws_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tws_checker
// Passive checker for the text whitespace stripper. It tracks register
// writes and byte transfers into the block, predicts the cleaned output of
// each accepted byte and compares every output transfer, field by field,
// with the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module tws_checker
    import tws_pkg::*;
    import tws_tb_pkg::*;
#(
    parameter int SPACE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic [2:0] m_tuser,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
        logic       done;
        logic       ovf;
    } strip_res_t;

    logic       skip_hash;
    logic       line_fresh;
    logic       in_hash_line;
    logic       line_text;
    logic       gap_pending;
    logic       emitted_any;
    logic       ws_dropped;
    logic [7:0] ws_buf [SPACE_DEPTH];
    int         ws_len;

    strip_res_t cleaned_q[$];
    int         mism = 0;

    function automatic logic is_ws(input logic [7:0] c);
        return c == SPACE_BYTE || c == TAB_BYTE || c == VTAB_BYTE ||
               c == FORMFEED_BYTE || c == CR_BYTE;
    endfunction

    function automatic strip_res_t mk_res(input logic [7:0] c, input logic v);
        strip_res_t r;
        r = '0;
        r.ch    = c;
        r.valid = v;
        return r;
    endfunction

    task automatic clear_text();
        line_fresh   = 1'b1;
        in_hash_line = 1'b0;
        line_text    = 1'b0;
        gap_pending  = 1'b0;
        emitted_any  = 1'b0;
        ws_dropped   = 1'b0;
        ws_len       = 0;
    endtask

    task automatic strip_byte(input logic [7:0] c, input logic eot);
        strip_res_t run[$];
        if (in_hash_line) begin
            if (c == NEWLINE_BYTE) begin
                in_hash_line = 1'b0;
                line_fresh   = 1'b1;
            end
        end else if (line_fresh && skip_hash && c == HASH_BYTE) begin
            in_hash_line = 1'b1;
            line_fresh   = 1'b0;
        end else if (c == NEWLINE_BYTE) begin
            if (line_text)
                run.push_back(mk_res(NEWLINE_BYTE, 1'b1));
            else
                gap_pending = 1'b1;
            line_fresh = 1'b1;
            line_text  = 1'b0;
            ws_len     = 0;
        end else if (is_ws(c)) begin
            if (ws_len < SPACE_DEPTH) begin
                ws_buf[ws_len] = c;
                ws_len++;
            end else begin
                ws_dropped = 1'b1;
            end
            line_fresh = 1'b0;
        end else begin
            if (!line_text) begin
                if (gap_pending && emitted_any)
                    run.push_back(mk_res(NEWLINE_BYTE, 1'b1));
                gap_pending = 1'b0;
            end
            for (int k = 0; k < ws_len; k++)
                run.push_back(mk_res(ws_buf[k], 1'b1));
            run.push_back(mk_res(c, 1'b1));
            ws_len      = 0;
            line_text   = 1'b1;
            emitted_any = 1'b1;
            line_fresh  = 1'b0;
        end

        if (eot) begin
            if (!in_hash_line && line_text)
                run.push_back(mk_res(NEWLINE_BYTE, 1'b1));
            if (run.size() == 0)
                run.push_back(mk_res(8'h00, 1'b0));
            run[run.size()-1].done = 1'b1;
        end
        foreach (run[i])
            run[i].ovf = ws_dropped;
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            cleaned_q.push_back(run[i]);

        if (eot)
            clear_text();
    endtask

    task automatic check_result();
        strip_res_t got;
        strip_res_t want;
        got.ch    = m_tdata;
        got.valid = m_tuser[0];
        got.last  = m_tlast;
        got.done  = m_tuser[1];
        got.ovf   = m_tuser[2];
        if (cleaned_q.size() == 0) begin
            mism++;
            if (mism <= 10)
                $display("unexpected output transfer: byte %h valid %b last %b done %b ovf %b",
                         got.ch, got.valid, got.last, got.done, got.ovf);
        end else begin
            want = cleaned_q.pop_front();
            if (got !== want) begin
                mism++;
                if (mism <= 10)
                    $display("mismatch: exp byte %h valid %b last %b done %b ovf %b, got byte %h valid %b last %b done %b ovf %b",
                             want.ch, want.valid, want.last, want.done, want.ovf,
                             got.ch, got.valid, got.last, got.done, got.ovf);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            skip_hash = 1'b0;
            clear_text();
            cleaned_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                skip_hash = cfg_data;
            if (s_tvalid && s_tready)
                strip_byte(s_tdata, s_tlast);
        end
        fail_count <= mism;
        pending    <= cleaned_q.size();
    end

endmodule

### dv/tb_text_whitespace_stripper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_whitespace_stripper
// Stimulus and verdict for the text whitespace stripper. A short directed
// set of texts is followed by random texts built from lines of words,
// whitespace runs, comment lines, long gaps and raw noise, with random
// register settings, random idling on both channels and one long output
// stall. Checking is left to tws_checker.
// ----------------------------------------------------------------------------
module tb_text_whitespace_stripper;
    import tws_pkg::*;
    import tws_tb_pkg::*;

    localparam int SPACE_DEPTH  = 32;
    localparam int SETTLE       = 2 * SPACE_DEPTH + 40;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 360;
    localparam int QUIET_TAIL   = 60;

    typedef enum int {
        LN_EMPTY,
        LN_BLANK,
        LN_COMMENT,
        LN_LONG_GAP,
        LN_NOISE,
        LN_WORDS
    } line_kind_e;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    int         fail_count;
    int         pending;

    logic       idle_on    = 1'b0;
    logic       hold_armed = 1'b0;
    int         sent       = 0;
    logic [7:0] text_q[$];

    text_whitespace_stripper #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    tws_checker #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // output side: random back-pressure, plus one long hold when armed
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_armed) begin
                hold_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 4))
            0: return SPACE_BYTE;
            1: return TAB_BYTE;
            2: return VTAB_BYTE;
            3: return FORMFEED_BYTE;
            default: return CR_BYTE;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(0, 3) != 0)
            return 8'h61 + 8'($urandom_range(0, 25));
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    task automatic add_ws(input int n);
        repeat (n) text_q.push_back(pick_ws());
    endtask

    task automatic add_word();
        repeat ($urandom_range(1, 4)) text_q.push_back(pick_letter());
    endtask

    task automatic make_random_text();
        int         nlines;
        int         r;
        line_kind_e kind;
        text_q.delete();
        nlines = $urandom_range(1, 5);
        for (int ln = 0; ln < nlines; ln++) begin
            r    = $urandom_range(0, 11);
            kind = (r > int'(LN_WORDS)) ? LN_WORDS : line_kind_e'(r);
            case (kind)
                LN_EMPTY: ;
                LN_BLANK: add_ws($urandom_range(1, 5));
                LN_COMMENT: begin
                    text_q.push_back(HASH_BYTE);
                    add_ws($urandom_range(0, 2));
                    add_word();
                end
                LN_LONG_GAP: begin
                    add_word();
                    add_ws($urandom_range(SPACE_DEPTH - 3, SPACE_DEPTH + 6));
                    add_word();
                end
                LN_NOISE: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        add_ws($urandom_range(1, 3));
                    add_word();
                    repeat ($urandom_range(0, 2)) begin
                        add_ws($urandom_range(1, 3));
                        add_word();
                    end
                    if ($urandom_range(0, 2) == 0)
                        add_ws($urandom_range(1, 4));
                end
            endcase
            if (ln != nlines - 1 || $urandom_range(0, 2) != 0)
                text_q.push_back(NEWLINE_BYTE);
        end
        if (text_q.size() == 0)
            text_q.push_back(NEWLINE_BYTE);
    endtask

    task automatic send_item(input logic [7:0] b, input logic eot);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_item(text_q[i], i == text_q.size() - 1);
    endtask

    // only while the block is idle: all output in, then time for silent items
    task automatic write_cfg(input logic v);
        s_tvalid <= 1'b0;
        do begin
            while (pending != 0) @(posedge aclk);
            repeat (SETTLE) @(posedge aclk);
        end while (pending != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int base;
        int guard;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leading blanks, whitespace-only line, blank run, odd blanks, 0x00/0xFF
        text_q = '{NEWLINE_BYTE, SPACE_BYTE, NEWLINE_BYTE, HASH_BYTE, TAB_BYTE, 8'h61,
                   SPACE_BYTE, CR_BYTE, NEWLINE_BYTE, NEWLINE_BYTE, NEWLINE_BYTE, 8'hFF,
                   VTAB_BYTE, FORMFEED_BYTE, NEWLINE_BYTE, 8'h00};
        send_text();
        // text of nothing but a newline: bare done marker
        text_q = '{NEWLINE_BYTE};
        send_text();
        write_cfg(1'b1);
        // comment line dropped, mid-line hash kept, end with pending whitespace
        text_q = '{HASH_BYTE, SPACE_BYTE, 8'h78, NEWLINE_BYTE, 8'h62, HASH_BYTE,
                   SPACE_BYTE};
        send_text();
        // text ending inside a comment line
        text_q = '{HASH_BYTE, 8'h79};
        send_text();

        write_cfg(1'b0);
        hold_armed = 1'b1;
        idle_on    = 1'b1;
        base       = sent;
        while (sent - base < RANDOM_ITEMS) begin
            if (sent - base > RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            make_random_text();
            send_text();
            if ($urandom_range(0, 4) == 0)
                write_cfg(1'($urandom_range(0, 1)));
        end
        idle_on = 1'b0;
        s_tvalid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
